[sv/assert_macros.svh]
// Assertion macros shared by the ALU pipeline files.
// No dependencies; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

[sv/alu8_pkg.sv]
// Types, operation codes and constants of the eight-bit ALU pipeline.
// No dependencies; used by every module of the block.
package alu8_pkg;

   // Operation codes.
   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_ADC  = 5'd1;
   localparam logic [4:0] OP_SUB  = 5'd2;
   localparam logic [4:0] OP_SBC  = 5'd3;
   localparam logic [4:0] OP_CP   = 5'd4;
   localparam logic [4:0] OP_AND  = 5'd5;
   localparam logic [4:0] OP_OR   = 5'd6;
   localparam logic [4:0] OP_XOR  = 5'd7;
   localparam logic [4:0] OP_INC  = 5'd8;
   localparam logic [4:0] OP_DEC  = 5'd9;
   localparam logic [4:0] OP_RLC  = 5'd10;
   localparam logic [4:0] OP_RRC  = 5'd11;
   localparam logic [4:0] OP_RL   = 5'd12;
   localparam logic [4:0] OP_RR   = 5'd13;
   localparam logic [4:0] OP_RLCA = 5'd14;
   localparam logic [4:0] OP_RRCA = 5'd15;
   localparam logic [4:0] OP_RLA  = 5'd16;
   localparam logic [4:0] OP_RRA  = 5'd17;
   localparam logic [4:0] OP_SLA  = 5'd18;
   localparam logic [4:0] OP_SRA  = 5'd19;
   localparam logic [4:0] OP_SRL  = 5'd20;
   localparam logic [4:0] OP_SWAP = 5'd21;
   localparam logic [4:0] OP_BIT  = 5'd22;
   localparam logic [4:0] OP_RES  = 5'd23;
   localparam logic [4:0] OP_SET  = 5'd24;
   localparam logic [4:0] OP_DAA  = 5'd25;
   localparam logic [4:0] OP_CPL  = 5'd26;
   localparam logic [4:0] OP_CCF  = 5'd27;
   localparam logic [4:0] OP_SCF  = 5'd28;

   // Flag bit positions within the four-bit flag word.
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Decimal adjust constants.
   localparam logic [7:0] DAA_ADJ_LO       = 8'h06;
   localparam logic [7:0] DAA_ADJ_HI       = 8'h60;
   localparam logic [7:0] DAA_BYTE_LIMIT   = 8'h99;
   localparam logic [3:0] DAA_NIBBLE_LIMIT = 4'h9;

   // Decoded request held after the first stage.
   typedef struct packed {
      logic [4:0] op;
      logic [7:0] target;
      logic [7:0] source;
      logic [7:0] mask;      // one-hot select of the bit index
      logic [3:0] flags;
      logic [7:0] addend;    // second adder operand, already inverted for subtraction
      logic       carry_in;
      logic       daa_carry;
   } dec_type;

   // Execution result held after the second stage.
   typedef struct packed {
      logic [7:0] result;
      logic [7:0] zero_src;  // byte tested for zero when the zero flag follows it
      logic       zero_from; // 1 when the zero flag follows zero_src
      logic [3:0] flags;     // flags with the zero bit final unless zero_from is set
      logic       writes;
   } exe_type;

endpackage

[sv/alu8_decode.sv]
// First pipeline stage: decodes the request and prepares the adder operands.
// Depends on alu8_pkg.
module alu8_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [4:0]        operation,
   input  logic [7:0]        target_value,
   input  logic [7:0]        source_value,
   input  logic [2:0]        bit_index,
   input  logic [3:0]        flags_in,
   output logic              out_valid,
   input  logic              out_ready,
   output alu8_pkg::dec_type out_data
);

   logic              valid_ff;
   logic              valid_in;
   alu8_pkg::dec_type data_ff;
   alu8_pkg::dec_type data_in;
   logic [7:0]        daa_adj;
   logic              daa_lo;
   logic              daa_hi;

   // The stage takes a request when it is empty or its content moves on.
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Decimal adjust decision, made on the incoming byte and flags.
   always_comb begin
      daa_lo = flags_in[alu8_pkg::FLAG_H];
      daa_hi = flags_in[alu8_pkg::FLAG_C];
      if (!flags_in[alu8_pkg::FLAG_N]) begin
         daa_lo = daa_lo || (target_value[3:0] > alu8_pkg::DAA_NIBBLE_LIMIT);
         daa_hi = daa_hi || (target_value > alu8_pkg::DAA_BYTE_LIMIT);
      end
      daa_adj = (daa_lo ? alu8_pkg::DAA_ADJ_LO : 8'h00) |
                (daa_hi ? alu8_pkg::DAA_ADJ_HI : 8'h00);
   end

   // Operand preparation: every add, subtract, step and adjust uses one adder.
   always_comb begin
      data_in.op        = operation;
      data_in.target    = target_value;
      data_in.source    = source_value;
      data_in.mask      = 8'b1 << bit_index;
      data_in.flags     = flags_in;
      data_in.daa_carry = daa_hi;
      data_in.addend    = source_value;
      data_in.carry_in  = 1'b0;
      unique case (operation) inside
         alu8_pkg::OP_ADD: begin
            data_in.addend   = source_value;
            data_in.carry_in = 1'b0;
         end
         alu8_pkg::OP_ADC: begin
            data_in.addend   = source_value;
            data_in.carry_in = flags_in[alu8_pkg::FLAG_C];
         end
         alu8_pkg::OP_SUB, alu8_pkg::OP_CP: begin
            data_in.addend   = ~source_value;
            data_in.carry_in = 1'b1;
         end
         alu8_pkg::OP_SBC: begin
            data_in.addend   = ~source_value;
            data_in.carry_in = ~flags_in[alu8_pkg::FLAG_C];
         end
         alu8_pkg::OP_INC: begin
            data_in.addend   = 8'h00;
            data_in.carry_in = 1'b1;
         end
         alu8_pkg::OP_DEC: begin
            data_in.addend   = 8'hFF;
            data_in.carry_in = 1'b0;
         end
         alu8_pkg::OP_DAA: begin
            if (flags_in[alu8_pkg::FLAG_N]) begin
               data_in.addend   = ~daa_adj;
               data_in.carry_in = 1'b1;
            end else begin
               data_in.addend   = daa_adj;
               data_in.carry_in = 1'b0;
            end
         end
         default: begin
            data_in.addend   = source_value;
            data_in.carry_in = 1'b0;
         end
      endcase
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

[sv/alu8_execute.sv]
// Second pipeline stage: adder, logic, shifts and bit operations with their flags.
// Depends on alu8_pkg.
module alu8_execute (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  alu8_pkg::dec_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output alu8_pkg::exe_type out_data
);

   logic              valid_ff;
   logic              valid_in;
   alu8_pkg::exe_type data_ff;
   alu8_pkg::exe_type data_in;
   logic [4:0]        sum_lo;
   logic [8:0]        sum;
   logic              c4;
   logic              c8;
   logic [7:0]        t;
   logic [3:0]        fi;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   assign t  = in_data.target;
   assign fi = in_data.flags;

   // Shared adder with carries out of bit 3 and bit 7.
   assign sum_lo = {1'b0, t[3:0]} + {1'b0, in_data.addend[3:0]} + {4'b0, in_data.carry_in};
   assign sum    = {1'b0, t} + {1'b0, in_data.addend} + {8'b0, in_data.carry_in};
   assign c4     = sum_lo[4];
   assign c8     = sum[8];

   // Result and flag selection per operation.
   always_comb begin
      data_in.result    = t;
      data_in.zero_src  = t;
      data_in.zero_from = 1'b0;
      data_in.flags     = fi;
      data_in.writes    = 1'b1;
      unique case (in_data.op) inside
         alu8_pkg::OP_ADD, alu8_pkg::OP_ADC: begin
            data_in.result    = sum[7:0];
            data_in.zero_src  = sum[7:0];
            data_in.zero_from = 1'b1;
            data_in.flags     = {1'b0, 1'b0, c4, c8};
         end
         alu8_pkg::OP_SUB, alu8_pkg::OP_SBC: begin
            data_in.result    = sum[7:0];
            data_in.zero_src  = sum[7:0];
            data_in.zero_from = 1'b1;
            data_in.flags     = {1'b0, 1'b1, !c4, !c8};
         end
         alu8_pkg::OP_CP: begin
            data_in.zero_src  = sum[7:0];
            data_in.zero_from = 1'b1;
            data_in.flags     = {1'b0, 1'b1, !c4, !c8};
            data_in.writes    = 1'b0;
         end
         alu8_pkg::OP_AND: begin
            data_in.result    = t & in_data.source;
            data_in.zero_src  = t & in_data.source;
            data_in.zero_from = 1'b1;
            data_in.flags     = 4'b0010;
         end
         alu8_pkg::OP_OR: begin
            data_in.result    = t | in_data.source;
            data_in.zero_src  = t | in_data.source;
            data_in.zero_from = 1'b1;
            data_in.flags     = 4'b0000;
         end
         alu8_pkg::OP_XOR: begin
            data_in.result    = t ^ in_data.source;
            data_in.zero_src  = t ^ in_data.source;
            data_in.zero_from = 1'b1;
            data_in.flags     = 4'b0000;
         end
         alu8_pkg::OP_INC: begin
            data_in.result    = sum[7:0];
            data_in.zero_src  = sum[7:0];
            data_in.zero_from = 1'b1;
            data_in.flags     = {1'b0, 1'b0, c4, fi[alu8_pkg::FLAG_C]};
         end
         alu8_pkg::OP_DEC: begin
            data_in.result    = sum[7:0];
            data_in.zero_src  = sum[7:0];
            data_in.zero_from = 1'b1;
            data_in.flags     = {1'b0, 1'b1, !c4, fi[alu8_pkg::FLAG_C]};
         end
         alu8_pkg::OP_RLC, alu8_pkg::OP_RLCA: begin
            data_in.result    = {t[6:0], t[7]};
            data_in.zero_src  = {t[6:0], t[7]};
            data_in.zero_from = (in_data.op == alu8_pkg::OP_RLC);
            data_in.flags     = {3'b000, t[7]};
         end
         alu8_pkg::OP_RRC, alu8_pkg::OP_RRCA: begin
            data_in.result    = {t[0], t[7:1]};
            data_in.zero_src  = {t[0], t[7:1]};
            data_in.zero_from = (in_data.op == alu8_pkg::OP_RRC);
            data_in.flags     = {3'b000, t[0]};
         end
         alu8_pkg::OP_RL, alu8_pkg::OP_RLA: begin
            data_in.result    = {t[6:0], fi[alu8_pkg::FLAG_C]};
            data_in.zero_src  = {t[6:0], fi[alu8_pkg::FLAG_C]};
            data_in.zero_from = (in_data.op == alu8_pkg::OP_RL);
            data_in.flags     = {3'b000, t[7]};
         end
         alu8_pkg::OP_RR, alu8_pkg::OP_RRA: begin
            data_in.result    = {fi[alu8_pkg::FLAG_C], t[7:1]};
            data_in.zero_src  = {fi[alu8_pkg::FLAG_C], t[7:1]};
            data_in.zero_from = (in_data.op == alu8_pkg::OP_RR);
            data_in.flags     = {3'b000, t[0]};
         end
         alu8_pkg::OP_SLA: begin
            data_in.result    = {t[6:0], 1'b0};
            data_in.zero_src  = {t[6:0], 1'b0};
            data_in.zero_from = 1'b1;
            data_in.flags     = {3'b000, t[7]};
         end
         alu8_pkg::OP_SRA: begin
            data_in.result    = {t[7], t[7:1]};
            data_in.zero_src  = {t[7], t[7:1]};
            data_in.zero_from = 1'b1;
            data_in.flags     = {3'b000, t[0]};
         end
         alu8_pkg::OP_SRL: begin
            data_in.result    = {1'b0, t[7:1]};
            data_in.zero_src  = {1'b0, t[7:1]};
            data_in.zero_from = 1'b1;
            data_in.flags     = {3'b000, t[0]};
         end
         alu8_pkg::OP_SWAP: begin
            data_in.result    = {t[3:0], t[7:4]};
            data_in.zero_src  = {t[3:0], t[7:4]};
            data_in.zero_from = 1'b1;
            data_in.flags     = 4'b0000;
         end
         alu8_pkg::OP_BIT: begin
            data_in.flags  = {((t & in_data.mask) == 8'h00), 1'b0, 1'b1,
                              fi[alu8_pkg::FLAG_C]};
            data_in.writes = 1'b0;
         end
         alu8_pkg::OP_RES: begin
            data_in.result = t & ~in_data.mask;
         end
         alu8_pkg::OP_SET: begin
            data_in.result = t | in_data.mask;
         end
         alu8_pkg::OP_DAA: begin
            data_in.result    = sum[7:0];
            data_in.zero_src  = sum[7:0];
            data_in.zero_from = 1'b1;
            data_in.flags     = {1'b0, fi[alu8_pkg::FLAG_N], 1'b0, in_data.daa_carry};
         end
         alu8_pkg::OP_CPL: begin
            data_in.result = ~t;
            data_in.flags  = fi | 4'b0110;
         end
         alu8_pkg::OP_CCF: begin
            data_in.flags  = {fi[alu8_pkg::FLAG_Z], 2'b00, ~fi[alu8_pkg::FLAG_C]};
            data_in.writes = 1'b0;
         end
         alu8_pkg::OP_SCF: begin
            data_in.flags  = {fi[alu8_pkg::FLAG_Z], 2'b00, 1'b1};
            data_in.writes = 1'b0;
         end
         default: begin
            // Undefined codes pass the byte and flags through without a write.
            data_in.writes = 1'b0;
         end
      endcase
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

[sv/alu8_flags.sv]
// Third pipeline stage: zero detection, final flag word and the output register.
// Depends on alu8_pkg.
module alu8_flags (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  alu8_pkg::exe_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        result_value,
   output logic [3:0]        flags_out,
   output logic              writes_target
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] result_ff;
   logic [3:0] flags_ff;
   logic [3:0] flags_in;
   logic       writes_ff;

   assign in_ready      = !valid_ff || out_ready;
   assign valid_in      = in_ready ? in_valid : valid_ff;
   assign out_valid     = valid_ff;
   assign result_value  = result_ff;
   assign flags_out     = flags_ff;
   assign writes_target = writes_ff;

   // The zero flag follows the tested byte where the operation asks for it.
   always_comb begin
      flags_in = in_data.flags;
      if (in_data.zero_from) begin
         flags_in[alu8_pkg::FLAG_Z] = (in_data.zero_src == 8'h00);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff <= in_data.result;
         flags_ff  <= flags_in;
         writes_ff <= in_data.writes;
      end
   end

endmodule

[sv/eight_bit_alu_with_flags.sv]
// Eight-bit ALU with Z, N, H and C flags, built as a three-stage pipeline (decode and
// operand preparation, execute, flag assembly into the output register). A request
// accepted at a clock edge passes through the decode, execute and output registers in
// that order before its response shows on rsp_. A new request may be accepted in every
// cycle while rsp_ready does not stall the pipeline. Each stage holds its own valid bit
// and takes new content when it is empty or its content moves on, so a stall on rsp_ready
// fills the empty stages first and then holds req_ready low; nothing is dropped or
// repeated. Responses come in request order.
// Depends on alu8_pkg, alu8_decode, alu8_execute, alu8_flags and assert_macros.svh.
`include "assert_macros.svh"

module eight_bit_alu_with_flags (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [4:0] req_operation,
   input  logic [7:0] req_target_value,
   input  logic [7:0] req_source_value,
   input  logic [2:0] req_bit_index,
   input  logic [3:0] req_flags_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_result_value,
   output logic [3:0] rsp_flags_out,
   output logic       rsp_writes_target
);

   logic              s1_valid;
   logic              s2_ready;
   alu8_pkg::dec_type s1_data;
   logic              s2_valid;
   logic              s3_ready;
   alu8_pkg::exe_type s2_data;

   // Stage one: decode.
   alu8_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .operation    (req_operation),
      .target_value (req_target_value),
      .source_value (req_source_value),
      .bit_index    (req_bit_index),
      .flags_in     (req_flags_in),
      .out_valid    (s1_valid),
      .out_ready    (s2_ready),
      .out_data     (s1_data)
   );

   // Stage two: execute.
   alu8_execute u_execute (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s2_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s3_ready),
      .out_data  (s2_data)
   );

   // Stage three: flags and output register.
   alu8_flags u_flags (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s2_valid),
      .in_ready      (s3_ready),
      .in_data       (s2_data),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .result_value  (rsp_result_value),
      .flags_out     (rsp_flags_out),
      .writes_target (rsp_writes_target)
   );

   // An accepted request always occupies the first stage in the next cycle.
   `ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_valid && req_ready, s1_valid,
      "accepted request lost at decode")
   // A full pipeline under a stalled response side accepts nothing.
   `ASSERT_SAME(a_full_blocks, clock, reset,
      s1_valid && s2_valid && rsp_valid && !rsp_ready, !req_ready,
      "request accepted into a full pipeline")
   // A stalled execute stage keeps its content.
   `ASSERT_NEXT(a_s2_holds, clock, reset, s2_valid && !s3_ready, s2_valid,
      "execute stage dropped a stalled request")

endmodule
